/* hdl/primitive_rasterizer_core_assert.svh */
// Assertion macros for the rasterizer RTL.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef PRIMITIVE_RASTERIZER_CORE_ASSERT_SVH
`define PRIMITIVE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication.
`define PRC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PRC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/prc_pkg.sv */
package prc_pkg;

  // Frame geometry.
  localparam int FRAME_WIDTH  = 1024;
  localparam int FRAME_HEIGHT = 768;

  // Field widths.
  localparam int COORD_W = 10;
  localparam int COLOR_W = 8;
  localparam int INDEX_W = 20;

  // Cursors must count across the whole frame for a clear.
  localparam int FRAME_MAX = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int CUR_W     = ($clog2(FRAME_MAX) > COORD_W) ? $clog2(FRAME_MAX) : COORD_W;

  // Slope divider produces one quotient bit per cycle.
  localparam int DIV_CNT_W = $clog2(COORD_W + 1);

  localparam logic [COLOR_W-1:0] COLOR_WHITE = '1;

  // Outline edges in drawing order.
  localparam logic [1:0] EDGE_LEFT      = 2'd0;
  localparam logic [1:0] EDGE_ROW_END   = 2'd1;
  localparam logic [1:0] EDGE_ROW_START = 2'd2;
  localparam logic [1:0] EDGE_RIGHT     = 2'd3;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_LINE    = 2'd0,
    KIND_OUTLINE = 2'd1,
    KIND_FILL    = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_DIVIDE = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic               op;
    logic [1:0]         kind;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
  } prc_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [INDEX_W-1:0] frame_index;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;
    logic               last_pixel;
  } prc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic tick;
    logic div_start;
    logic out_pop;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic need_div;
    logic div_done;
    logic out_full;
  } dp_status_t;

  // Endpoints of one edge.
  typedef struct packed {
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
  } edge_t;

  // Result of a search for the next nonempty edge.
  typedef struct packed {
    logic       found;
    logic [1:0] edge_idx;
  } seek_t;

endpackage

/* hdl/prc_divider.sv */
module prc_divider
  import prc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COORD_W-1:0] dividend_i,
  input  logic [COORD_W-1:0] divisor_i,
  output logic               done_o,
  output logic [COORD_W-1:0] quotient_o,
  output logic [COORD_W-1:0] remainder_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [COORD_W-1:0]   quo_q, quo_d;
  logic [COORD_W-1:0]   rem_q, rem_d;
  logic [COORD_W-1:0]   div_q, div_d;
  logic [COORD_W:0]     trial;

  // One restoring step per cycle, most significant bit first.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, quo_q[COORD_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(COORD_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = COORD_W'(trial - {1'b0, div_q});
        quo_d = {quo_q[COORD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[COORD_W-1:0];
        quo_d = {quo_q[COORD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  // The last step is under way; its results are in place after this edge.
  assign done_o      = busy_q && (cnt_q == DIV_CNT_W'(1));
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* hdl/prc_datapath.sv */
module prc_datapath
  import prc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  input  prc_in_t    in_data_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  output prc_out_t   out_data_o
);

  // Primitive state.
  logic               active_q, active_d;
  logic [1:0]         kind_q, kind_d;
  logic [1:0]         edge_q, edge_d;
  logic [COORD_W-1:0] x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic [CUR_W-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COLOR_W-1:0] red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic               dy_neg_q, dy_neg_d;
  // Running quotient and remainder of the slope term.
  logic [COORD_W-1:0] q_acc_q, q_acc_d, r_acc_q, r_acc_d;
  // Output register.
  logic               out_valid_q, out_valid_d;
  prc_out_t           out_q, out_d;

  logic               div_done;
  logic [COORD_W-1:0] div_quo, div_rem;
  logic [COORD_W-1:0] dy_abs_in, dx_in;

  function automatic edge_t edge_ends(logic [1:0] kind, logic [1:0] e,
                                      logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                                      logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1);
    edge_t r;
    r = '{ax: x0, ay: y0, bx: x1, by: y1};
    if (kind != KIND_LINE) begin
      case (e)
        EDGE_LEFT:      r = '{ax: x0, ay: y0, bx: x0, by: y1};
        EDGE_ROW_END:   r = '{ax: x0, ay: y1, bx: x1, by: y1};
        EDGE_ROW_START: r = '{ax: x0, ay: y0, bx: x1, by: y0};
        default:        r = '{ax: x1, ay: y0, bx: x1, by: y1};
      endcase
    end
    return r;
  endfunction

  // Finds the first nonempty edge at or after the start index.
  function automatic seek_t seek(logic [1:0] kind, logic [2:0] start,
                                 logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                                 logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1);
    seek_t      s;
    logic [3:0] ne;
    s = '{found: 1'b0, edge_idx: 2'd0};
    if (kind == KIND_LINE) begin
      ne = {3'b000, (x0 == x1) ? (y1 >= y0) : (x1 >= x0)};
    end else begin
      ne = {y1 >= y0, x1 >= x0, x1 >= x0, y1 >= y0};
    end
    for (int i = 0; i < 4; i++) begin
      if (!s.found && (3'(i) >= start) && ne[i]) begin
        s.found    = 1'b1;
        s.edge_idx = 2'(i);
      end
    end
    return s;
  endfunction

  // Slope operands of a line, taken from the load transaction.
  assign dy_abs_in = (in_data_i.y_end < in_data_i.y_start) ?
                     (in_data_i.y_start - in_data_i.y_end) :
                     (in_data_i.y_end - in_data_i.y_start);
  assign dx_in     = in_data_i.x_end - in_data_i.x_start;

  prc_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (dy_abs_in),
    .divisor_i   (dx_in),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Status for the controller.
  always_comb begin
    status_o.is_tick  = (in_data_i.op == OP_TICK);
    status_o.need_div = (in_data_i.kind == KIND_LINE) &&
                        (in_data_i.x_end > in_data_i.x_start);
    status_o.div_done = div_done;
    status_o.out_full = out_valid_q;
  end

  // Load, pixel stepping and output register update.
  always_comb begin
    edge_t              eg;
    edge_t              en;
    seek_t              sk;
    logic               do_seek;
    logic [CUR_W-1:0]   px, py;
    logic [CUR_W-1:0]   xlo;
    logic [CUR_W:0]     xhi, yhi;
    logic [COORD_W-1:0] dx;
    logic [COORD_W:0]   r_sum;
    logic [31:0]        fi;

    active_d    = active_q;
    kind_d      = kind_q;
    edge_d      = edge_q;
    x0_d        = x0_q;
    y0_d        = y0_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    dy_neg_d    = dy_neg_q;
    q_acc_d     = q_acc_q;
    r_acc_d     = r_acc_q;
    out_valid_d = out_valid_q && !cmd_i.out_pop;
    out_d       = out_q;
    eg          = edge_ends(kind_q, edge_q, x0_q, y0_q, x1_q, y1_q);
    en          = eg;
    sk          = '{found: 1'b0, edge_idx: 2'd0};
    do_seek     = 1'b0;
    px          = '0;
    py          = '0;
    xlo         = '0;
    xhi         = (CUR_W+1)'(FRAME_WIDTH);
    yhi         = (CUR_W+1)'(FRAME_HEIGHT);
    dx          = x1_q - x0_q;
    r_sum       = {1'b0, r_acc_q} + {1'b0, div_rem};
    fi          = '0;

    if (cmd_i.load) begin
      // Latch a new primitive and find its first pixel.
      kind_d   = in_data_i.kind;
      x0_d     = in_data_i.x_start;
      y0_d     = in_data_i.y_start;
      x1_d     = in_data_i.x_end;
      y1_d     = in_data_i.y_end;
      red_d    = in_data_i.red_in;
      green_d  = in_data_i.green_in;
      blue_d   = in_data_i.blue_in;
      edge_d   = EDGE_LEFT;
      cur_x_d  = '0;
      cur_y_d  = '0;
      dy_neg_d = in_data_i.y_end < in_data_i.y_start;
      q_acc_d  = '0;
      r_acc_d  = '0;
      case (in_data_i.kind)
        KIND_LINE, KIND_OUTLINE: begin
          sk = seek(in_data_i.kind, 3'd0, in_data_i.x_start, in_data_i.y_start,
                    in_data_i.x_end, in_data_i.y_end);
          en = edge_ends(in_data_i.kind, sk.edge_idx, in_data_i.x_start,
                         in_data_i.y_start, in_data_i.x_end, in_data_i.y_end);
          active_d = sk.found;
          if (sk.found) begin
            edge_d  = sk.edge_idx;
            cur_x_d = CUR_W'(en.ax);
            cur_y_d = CUR_W'(en.ay);
          end
        end
        KIND_FILL: begin
          active_d = (in_data_i.x_end > in_data_i.x_start) &&
                     (in_data_i.y_end > in_data_i.y_start);
          cur_x_d  = CUR_W'(in_data_i.x_start);
          cur_y_d  = CUR_W'(in_data_i.y_start);
        end
        default: begin
          red_d    = COLOR_WHITE;
          green_d  = COLOR_WHITE;
          blue_d   = COLOR_WHITE;
          active_d = 1'b1;
        end
      endcase
    end else if (cmd_i.tick && active_q) begin
      if ((kind_q == KIND_LINE) || (kind_q == KIND_OUTLINE)) begin
        if (eg.ax == eg.bx) begin
          // Vertical edge: step in y.
          px = CUR_W'(eg.ax);
          py = cur_y_q;
          if (cur_y_q < CUR_W'(eg.by)) begin
            cur_y_d = cur_y_q + CUR_W'(1);
          end else begin
            do_seek = 1'b1;
          end
        end else begin
          // Sloped or horizontal edge: step in x, y from the running quotient.
          px = cur_x_q;
          py = dy_neg_q ? CUR_W'(eg.ay - q_acc_q) : CUR_W'(eg.ay + q_acc_q);
          if (cur_x_q < CUR_W'(eg.bx)) begin
            cur_x_d = cur_x_q + CUR_W'(1);
            if (kind_q == KIND_LINE) begin
              if (r_sum >= {1'b0, dx}) begin
                r_acc_d = COORD_W'(r_sum - {1'b0, dx});
                q_acc_d = q_acc_q + div_quo + COORD_W'(1);
              end else begin
                r_acc_d = r_sum[COORD_W-1:0];
                q_acc_d = q_acc_q + div_quo;
              end
            end
          end else begin
            do_seek = 1'b1;
          end
        end
        if (do_seek) begin
          sk = seek(kind_q, {1'b0, edge_q} + 3'd1, x0_q, y0_q, x1_q, y1_q);
          en = edge_ends(kind_q, sk.edge_idx, x0_q, y0_q, x1_q, y1_q);
          active_d = sk.found;
          if (sk.found) begin
            edge_d  = sk.edge_idx;
            cur_x_d = CUR_W'(en.ax);
            cur_y_d = CUR_W'(en.ay);
          end
        end
      end else begin
        // Fill and clear scan row by row.
        if (kind_q == KIND_FILL) begin
          xlo = CUR_W'(x0_q);
          xhi = (CUR_W+1)'(x1_q);
          yhi = (CUR_W+1)'(y1_q);
        end
        px = cur_x_q;
        py = cur_y_q;
        if (({1'b0, cur_x_q} + (CUR_W+1)'(1)) < xhi) begin
          cur_x_d = cur_x_q + CUR_W'(1);
        end else begin
          cur_x_d = xlo;
          if (({1'b0, cur_y_q} + (CUR_W+1)'(1)) < yhi) begin
            cur_y_d = cur_y_q + CUR_W'(1);
          end else begin
            active_d = 1'b0;
          end
        end
      end
      fi                = 32'(px) + 32'(FRAME_WIDTH) * 32'(py);
      out_valid_d       = 1'b1;
      out_d.pixel_x     = px[COORD_W-1:0];
      out_d.pixel_y     = py[COORD_W-1:0];
      out_d.frame_index = fi[INDEX_W-1:0];
      out_d.red_out     = red_q;
      out_d.green_out   = green_q;
      out_d.blue_out    = blue_q;
      out_d.last_pixel  = !active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      kind_q      <= KIND_LINE;
      edge_q      <= EDGE_LEFT;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      kind_q      <= kind_d;
      edge_q      <= edge_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q     <= x0_d;
    y0_q     <= y0_d;
    x1_q     <= x1_d;
    y1_q     <= y1_d;
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    red_q    <= red_d;
    green_q  <= green_d;
    blue_q   <= blue_d;
    dy_neg_q <= dy_neg_d;
    q_acc_q  <= q_acc_d;
    r_acc_q  <= r_acc_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/prc_ctrl.sv */
`include "primitive_rasterizer_core_assert.svh"

module prc_ctrl
  import prc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output logic       in_stall_o,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.div_start) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs: input handshake and datapath commands.
  always_comb begin
    in_stall_o      = (state_q != ST_IDLE) || (status_i.out_full && out_stall_i);
    accept          = in_valid_i && !in_stall_o;
    cmd_o.load      = accept && !status_i.is_tick;
    cmd_o.tick      = accept && status_i.is_tick;
    cmd_o.div_start = accept && !status_i.is_tick && status_i.need_div;
    cmd_o.out_pop   = status_i.out_full && !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PRC_ASSERT_NEXT(a_div_start_enters_divide, cmd_o.div_start, state_q == ST_DIVIDE,
                   "slope division started without entering the divide state")
  `PRC_ASSERT_IMP(a_div_done_only_in_divide, status_i.div_done, state_q == ST_DIVIDE,
                  "divider finished outside the divide state")
  `PRC_ASSERT_IMP(a_no_transaction_in_divide, state_q == ST_DIVIDE,
                  !cmd_o.load && !cmd_o.tick,
                  "input transaction taken while the slope divider runs")

endmodule

/* hdl/primitive_rasterizer_core.sv */
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_stall_o   in_data_i  (prc_in_t: load or tick)
// out      output     out_valid_o/out_stall_i out_data_o (prc_out_t: one pixel)
//
// A tick transaction yields at most one pixel in the output register.
// A load of a line whose x_end exceeds x_start also starts the radix-2 slope divider, and
// the next input transaction is stalled while it produces its ten quotient bits.
// Reset clears the controller and leaves no primitive active.
// A full output register that is stalled holds off the next input transaction.
module primitive_rasterizer_core
  import prc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  prc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output prc_out_t out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  prc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  prc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
